// ===== hw/rtl/lae_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lae_pkg;

  // default sizes of the elapsed counter and of the level arithmetic
  localparam int COUNT_BITS_DEF = 24;
  localparam int LEVEL_BITS_DEF = 16;

  // port field widths
  localparam int RAMP_W   = 24;
  localparam int LEVEL_W  = 16;
  localparam int STAGE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam logic [RAMP_W-1:0]  ATTACK_RST  = 24'd4410;
  localparam logic [RAMP_W-1:0]  DECAY_RST   = 24'd882;
  localparam logic [RAMP_W-1:0]  RELEASE_RST = 24'd88200;
  localparam logic [LEVEL_W-1:0] PEAK_RST    = 16'd65535;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd52428;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

  // envelope stage codes
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lae_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// gate channel, one transfer per audio sample
interface lae_in_if;
  logic valid;
  logic ready;
  logic gate;
  modport source (output valid, output gate, input ready);
  modport sink (input valid, input gate, output ready);
endinterface

// envelope result channel
interface lae_out_if;
  logic                          valid;
  logic                          ready;
  logic [lae_pkg::LEVEL_W-1:0]   level;
  logic [lae_pkg::STAGE_W-1:0]   stage;
  modport source (output valid, output level, output stage, input ready);
  modport sink (input valid, input level, input stage, output ready);
endinterface

// register write channel
interface lae_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lae_pkg::CFG_IDX_W-1:0]  index;
  logic [lae_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/linear_adsr_envelope_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                    transfer
// in_if     in   gate (1)                   valid && ready
// out_if    out  level (16), stage (2)      valid && ready
// cfg_if    in   index (3), data (24)       valid && ready, ready always high
//
// each sample passes, in order, through taking the gate, the bit-serial multiply, the
// restoring divider and the write of the output register, all on the shared
// shift-add / shift-subtract datapath.
// synchronous reset restores the default registers and a released note at zero count.
// a waiting result does not block the next sample; the result stage holds only while
// the output register is still full.
module linear_adsr_envelope_core #(
  parameter int COUNT_BITS = lae_pkg::COUNT_BITS_DEF,
  parameter int LEVEL_BITS = lae_pkg::LEVEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lae_in_if.sink           in_if,
  lae_out_if.source        out_if,
  lae_cfg_if.sink          cfg_if
);

  localparam int RW     = lae_pkg::RAMP_W;
  localparam int LW     = lae_pkg::LEVEL_W;
  localparam int PW     = COUNT_BITS + LW;
  localparam int CMP_W  = ((COUNT_BITS > RW) ? COUNT_BITS : RW) + 1;
  localparam int STEP_W = $clog2(PW + 1);

  localparam logic [RW-1:0] RAMP_MASK = (COUNT_BITS >= RW) ? {RW{1'b1}} :
                                        RW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [LW-1:0] LVL_MASK  = (LEVEL_BITS >= LW) ? {LW{1'b1}} :
                                        LW'((64'd1 << LEVEL_BITS) - 64'd1);
  localparam logic [LW-1:0] LVL_FLOOR = LW'((64'd1 << LEVEL_BITS) / 64'd10000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [RW-1:0] attack_r, decay_r, release_r;
  logic [LW-1:0] peak_r, sustain_r;

  // note state
  logic                  held_r, held_nxt;
  logic [COUNT_BITS-1:0] elapsed_r, elapsed_nxt;

  // sequencer and datapath
  lae_pkg::state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]     mcand_r, mcand_nxt;
  logic [LW-1:0]     mplier_r, mplier_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [RW-1:0]     div_r, div_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [LW-1:0]     quot_r, quot_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LW-1:0]     base_r, base_nxt;
  logic              sub_r, sub_nxt;
  logic [lae_pkg::STAGE_W-1:0] stage_r, stage_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [LW-1:0]               out_level_r, out_level_nxt;
  logic [lae_pkg::STAGE_W-1:0] out_stage_r, out_stage_nxt;

  // accept-time decode
  logic [COUNT_BITS-1:0] t_cur;
  logic [RW-1:0]         a_len, d_len, r_len;
  logic [CMP_W-1:0]      t_ext, a_ext, ad_sum, dt;
  logic                  rise_up;

  // divider step and final level
  logic [RW:0]   trial;
  logic          trial_ge;
  logic [LW-1:0] lvl_raw, lvl_fin;

  assign cfg_if.ready  = 1'b1;
  assign in_if.ready   = (state_r == lae_pkg::ST_IDLE);
  assign out_if.valid  = out_valid_r;
  assign out_if.level  = out_level_r;
  assign out_if.stage  = out_stage_r;

  // counter restarts on a gate change, zero ramp lengths count as one
  always_comb begin
    t_cur   = (in_if.gate != held_r) ? '0 : elapsed_r;
    a_len   = (attack_r == '0) ? RW'(1) : attack_r;
    d_len   = (decay_r == '0) ? RW'(1) : decay_r;
    r_len   = (release_r == '0) ? RW'(1) : release_r;
    t_ext   = CMP_W'(t_cur);
    a_ext   = CMP_W'(a_len);
    ad_sum  = CMP_W'(a_len) + CMP_W'(d_len);
    dt      = t_ext - a_ext;
    rise_up = (sustain_r >= peak_r);
  end

  // one restoring divide step
  always_comb begin
    trial    = {rem_r, acc_r[PW-1]};
    trial_ge = (trial >= {1'b0, div_r});
  end

  // clamp at zero on the falling side, then squash tiny levels
  always_comb begin
    if (sub_r) begin
      lvl_raw = (ovf_r || (quot_r >= base_r)) ? '0 : base_r - quot_r;
    end else begin
      lvl_raw = base_r + quot_r;
    end
    lvl_fin = (lvl_raw <= LVL_FLOOR) ? '0 : lvl_raw;
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    elapsed_nxt   = elapsed_r;
    cnt_nxt       = cnt_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    ovf_nxt       = ovf_r;
    base_nxt      = base_r;
    sub_nxt       = sub_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_stage_nxt = out_stage_r;

    // result transfer empties the output register
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lae_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          held_nxt    = in_if.gate;
          elapsed_nxt = (t_cur == COUNT_MAX) ? t_cur : t_cur + 1'b1;
          acc_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = lae_pkg::ST_MUL;
          if (!in_if.gate) begin
            stage_nxt  = lae_pkg::STAGE_RELEASE;
            mcand_nxt  = PW'(t_cur);
            mplier_nxt = sustain_r;
            base_nxt   = sustain_r;
            sub_nxt    = 1'b1;
            div_nxt    = r_len;
          end else if (t_ext <= a_ext) begin
            stage_nxt  = lae_pkg::STAGE_ATTACK;
            mcand_nxt  = PW'(t_cur);
            mplier_nxt = peak_r;
            base_nxt   = '0;
            sub_nxt    = 1'b0;
            div_nxt    = a_len;
          end else if (t_ext <= ad_sum) begin
            stage_nxt  = lae_pkg::STAGE_DECAY;
            mcand_nxt  = PW'(dt[COUNT_BITS-1:0]);
            mplier_nxt = rise_up ? sustain_r - peak_r : peak_r - sustain_r;
            base_nxt   = peak_r;
            sub_nxt    = !rise_up;
            div_nxt    = d_len;
          end else begin
            stage_nxt  = lae_pkg::STAGE_SUSTAIN;
            mcand_nxt  = '0;
            mplier_nxt = '0;
            base_nxt   = sustain_r;
            sub_nxt    = 1'b0;
            div_nxt    = d_len;
          end
        end
      end

      // shift-add multiply, one multiplier bit a cycle
      lae_pkg::ST_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(LW - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quot_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = lae_pkg::ST_DIV;
        end
      end

      // restoring divide, one quotient bit a cycle, sticky overflow above the level width
      lae_pkg::ST_DIV: begin
        if (trial_ge) begin
          rem_nxt = RW'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[RW-1:0];
        end
        acc_nxt  = acc_r << 1;
        quot_nxt = {quot_r[LW-2:0], trial_ge};
        ovf_nxt  = ovf_r | quot_r[LW-1];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(PW - 1)) begin
          state_nxt = lae_pkg::ST_DONE;
        end
      end

      // load the output register once it is free
      lae_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = lvl_fin;
          out_stage_nxt = stage_r;
          state_nxt     = lae_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lae_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lae_pkg::ST_IDLE;
      held_r      <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    ovf_r       <= ovf_nxt;
    base_r      <= base_nxt;
    sub_r       <= sub_nxt;
    stage_r     <= stage_nxt;
    out_level_r <= out_level_nxt;
    out_stage_r <= out_stage_nxt;
  end

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= lae_pkg::ATTACK_RST;
      decay_r   <= lae_pkg::DECAY_RST;
      release_r <= lae_pkg::RELEASE_RST;
      peak_r    <= lae_pkg::PEAK_RST & LVL_MASK;
      sustain_r <= lae_pkg::SUSTAIN_RST & LVL_MASK;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        lae_pkg::CFG_ATTACK:  attack_r  <= RW'(cfg_if.data) & RAMP_MASK;
        lae_pkg::CFG_DECAY:   decay_r   <= RW'(cfg_if.data) & RAMP_MASK;
        lae_pkg::CFG_RELEASE: release_r <= RW'(cfg_if.data) & RAMP_MASK;
        lae_pkg::CFG_PEAK:    peak_r    <= cfg_if.data[LW-1:0] & LVL_MASK;
        lae_pkg::CFG_SUSTAIN: sustain_r <= cfg_if.data[LW-1:0] & LVL_MASK;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/linear_adsr_envelope_core_tb.sv =====
`timescale 1ns / 1ps
module linear_adsr_envelope_core_tb;

  // one sample through the shared multiply / divide datapath
  localparam int SAMPLE_CYCLES = lae_pkg::COUNT_BITS_DEF + 34;
  localparam int QUIET_LIMIT = 5000;
  localparam int RUN_CAP = 40;
  localparam int LVL_W = lae_pkg::LEVEL_W;
  localparam int IDX_W = lae_pkg::CFG_IDX_W;
  localparam int DATA_W = lae_pkg::CFG_DATA_W;
  localparam longint unsigned LEVEL_FLOOR = (64'd1 << lae_pkg::LEVEL_BITS_DEF) / 10000;
  localparam logic [lae_pkg::COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [lae_pkg::LEVEL_W-1:0] level;
    logic [lae_pkg::STAGE_W-1:0] stage;
  } envelope_t;

  logic clk;
  logic rst_n;

  lae_in_if  gate_ch ();
  lae_out_if env_ch ();
  lae_cfg_if reg_ch ();

  linear_adsr_envelope_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (gate_ch),
    .out_if (env_ch),
    .cfg_if (reg_ch)
  );

  // envelope settings and note state as the block should hold them
  logic [lae_pkg::RAMP_W-1:0]         attack_len  = lae_pkg::ATTACK_RST;
  logic [lae_pkg::RAMP_W-1:0]         decay_len   = lae_pkg::DECAY_RST;
  logic [lae_pkg::RAMP_W-1:0]         release_len = lae_pkg::RELEASE_RST;
  logic [lae_pkg::LEVEL_W-1:0]        peak        = lae_pkg::PEAK_RST;
  logic [lae_pkg::LEVEL_W-1:0]        sustain     = lae_pkg::SUSTAIN_RST;
  logic [lae_pkg::COUNT_BITS_DEF-1:0] elapsed     = '0;
  logic                               key_down    = 1'b0;

  envelope_t levels_due[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        send_gap_pct = 0;
  int        ready_stall_pct = 0;
  int        quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // next envelope sample for one gate value, advancing the note state
  function automatic envelope_t next_envelope(input logic g);
    longint unsigned a, d, r, p, s, t, q, dt, lvl;
    envelope_t res;
    a = (attack_len == 0) ? 1 : attack_len;
    d = (decay_len == 0) ? 1 : decay_len;
    r = (release_len == 0) ? 1 : release_len;
    p = peak;
    s = sustain;
    if (g != key_down) begin
      elapsed  = '0;
      key_down = g;
    end
    t = elapsed;
    if (key_down) begin
      if (t <= a) begin
        res.stage = lae_pkg::STAGE_ATTACK;
        lvl = (t * p) / a;
      end else if (t <= a + d) begin
        res.stage = lae_pkg::STAGE_DECAY;
        dt = t - a;
        if (s >= p) lvl = p + (dt * (s - p)) / d;
        else        lvl = p - (dt * (p - s)) / d;
      end else begin
        res.stage = lae_pkg::STAGE_SUSTAIN;
        lvl = s;
      end
    end else begin
      // release always starts from sustain, whatever the level was
      res.stage = lae_pkg::STAGE_RELEASE;
      q = (t * s) / r;
      lvl = (q >= s) ? 0 : s - q;
    end
    if (lvl <= LEVEL_FLOOR) lvl = 0;
    if (elapsed != COUNT_TOP) elapsed = elapsed + 1'b1;
    res.level = LVL_W'(lvl);
    return res;
  endfunction

  // register writes as they land
  always @(posedge clk) begin
    if (rst_n && reg_ch.valid && reg_ch.ready) begin
      case (reg_ch.index)
        lae_pkg::CFG_ATTACK:  attack_len  = reg_ch.data;
        lae_pkg::CFG_DECAY:   decay_len   = reg_ch.data;
        lae_pkg::CFG_RELEASE: release_len = reg_ch.data;
        lae_pkg::CFG_PEAK:    peak        = reg_ch.data[LVL_W-1:0];
        lae_pkg::CFG_SUSTAIN: sustain     = reg_ch.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // one expected sample per gate transfer
  always @(posedge clk) begin
    if (rst_n && gate_ch.valid && gate_ch.ready)
      levels_due.push_back(next_envelope(gate_ch.gate));
  end

  // compare each result transfer against the oldest expected sample
  always @(posedge clk) begin
    envelope_t want;
    if (rst_n && env_ch.valid && env_ch.ready) begin
      if (levels_due.size() == 0) begin
        $display("%0t unexpected result: level %0d stage %0d", $time, env_ch.level,
                 env_ch.stage);
        mismatch_count++;
      end else begin
        want = levels_due.pop_front();
        if (env_ch.level !== want.level) begin
          $display("%0t level: expected %0d, got %0d", $time, want.level, env_ch.level);
          mismatch_count++;
        end
        if (env_ch.stage !== want.stage) begin
          $display("%0t stage: expected %0d, got %0d", $time, want.stage, env_ch.stage);
          mismatch_count++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    env_ch.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // give up when no channel has moved for too long
  always @(posedge clk) begin
    if ((gate_ch.valid && gate_ch.ready) || (env_ch.valid && env_ch.ready) ||
        (reg_ch.valid && reg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender idles cycle by cycle before each transfer
  task automatic send_gate(input logic g);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      gate_ch.valid <= 1'b0;
      @(posedge clk);
    end
    gate_ch.valid <= 1'b1;
    gate_ch.gate  <= g;
    do @(posedge clk); while (gate_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (reg_ch.ready !== 1'b1);
  endtask

  // stop the gate stream and wait for every outstanding sample
  task automatic drain;
    gate_ch.valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_envelope(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] d,
                              input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] p,
                              input logic [DATA_W-1:0] s);
    drain();
    write_reg(lae_pkg::CFG_ATTACK, a);
    write_reg(lae_pkg::CFG_DECAY, d);
    write_reg(lae_pkg::CFG_RELEASE, r);
    write_reg(lae_pkg::CFG_PEAK, p);
    write_reg(lae_pkg::CFG_SUSTAIN, s);
    reg_ch.valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_ramp();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom());
      default: return DATA_W'($urandom_range(1, 12));
    endcase
  endfunction

  // level with junk in the bits above the register width
  function automatic logic [DATA_W-1:0] pick_level();
    logic [LVL_W-1:0] lvl;
    case ($urandom_range(0, 7))
      0:       lvl = '0;
      1:       lvl = '1;
      2:       lvl = LVL_W'($urandom_range(0, 12));
      default: lvl = LVL_W'($urandom());
    endcase
    return {(DATA_W - LVL_W)'($urandom()), lvl};
  endfunction

  // length of a held or released stretch, often just past the ramp end
  function automatic int run_len(input int span);
    int top;
    top = (span + 3 > RUN_CAP) ? RUN_CAP : span + 3;
    if (top == span + 3 && $urandom_range(0, 1) == 1) return span + $urandom_range(1, 3);
    return $urandom_range(1, top);
  endfunction

  // straight out of reset the note is released at zero count
  task automatic test_release_after_reset;
    send_gate(1'b0);
    send_gate(1'b0);
  endtask

  // peak at full scale and sustain at zero, short ramps
  task automatic test_full_swing;
    set_envelope(2, 2, 3, '1, '0);
    repeat (6) send_gate(1'b1);
    repeat (2) send_gate(1'b0);
  endtask

  // zero ramp lengths act as one, decay rising to full-scale sustain
  task automatic test_rising_decay;
    set_envelope(0, 0, 0, 7, LVL_W'('1));
    repeat (4) send_gate(1'b1);
    repeat (2) send_gate(1'b0);
  endtask

  // levels at or under the floor collapse to zero
  task automatic test_small_levels;
    set_envelope(1, 1, 2, 6, 13);
    repeat (4) send_gate(1'b1);
    repeat (3) send_gate(1'b0);
  endtask

  // unused indexes are ignored, upper bits of level writes dropped, longest attack and release
  task automatic test_register_writes;
    drain();
    for (int i = lae_pkg::CFG_SUSTAIN + 1; i < 2 ** IDX_W; i++)
      write_reg(IDX_W'(i), DATA_W'($urandom()));
    write_reg(lae_pkg::CFG_ATTACK, '1);
    write_reg(lae_pkg::CFG_DECAY, 1);
    write_reg(lae_pkg::CFG_RELEASE, '1);
    write_reg(lae_pkg::CFG_PEAK, 24'hABCDEF);
    write_reg(lae_pkg::CFG_SUSTAIN, 24'hFF1234);
    reg_ch.valid <= 1'b0;
    send_gate(1'b1);
    send_gate(1'b0);
  endtask

  // mostly whole notes with random settings, some stray gates
  task automatic test_random_notes(input int gap_pct, input int stall_pct, input int n_items);
    int target;
    int a, d, r;
    logic [DATA_W-1:0] a_raw, d_raw, r_raw;
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      a_raw = pick_ramp();
      d_raw = pick_ramp();
      r_raw = pick_ramp();
      a = (a_raw == 0) ? 1 : int'(a_raw);
      d = (d_raw == 0) ? 1 : int'(d_raw);
      r = (r_raw == 0) ? 1 : int'(r_raw);
      set_envelope(a_raw, d_raw, r_raw, pick_level(), pick_level());
      repeat ($urandom_range(2, 5)) begin
        if (items_sent >= target) break;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_gate(1'($urandom_range(0, 1)));
        end else begin
          repeat (run_len(a + d)) send_gate(1'b1);
          repeat (run_len(r)) send_gate(1'b0);
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    gate_ch.valid = 1'b0;
    gate_ch.gate  = 1'b0;
    reg_ch.valid  = 1'b0;
    reg_ch.index  = '0;
    reg_ch.data   = '0;
    env_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_release_after_reset();
    test_full_swing();
    test_rising_decay();
    test_small_levels();
    test_register_writes();
    test_random_notes(37, 46, 250);
    test_random_notes(46, 37, 250);
    test_random_notes(0, 0, 250);

    // let the last samples out, then a little longer for anything stray
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    drain();
    repeat (2 * SAMPLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && levels_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
